FILE: sv/cog_pkg.sv
// shared types and constants of the circle outline generator
package cog_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  localparam int          PT_IDX_W = 3;
  localparam logic [2:0]  LAST_PT  = 3'd7;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one step of work: the octant pair and what it is drawn around
  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        color;
    logic [7:0]         a;
    logic signed [8:0]  b;
    logic               done;
  } job_t;

endpackage

FILE: sv/cog_front.sv
// front part: takes start and step words, runs the midpoint recurrence
module cog_front
  import cog_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic        op,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  input  logic [7:0]  radius,
  input  logic [15:0] pen_color,
  output logic        q_push,
  output job_t        q_job,
  output logic        active
);

  logic               active_r, active_nxt;
  logic [15:0]        cx_r, cx_nxt;
  logic [15:0]        cy_r, cy_nxt;
  logic [15:0]        color_r, color_nxt;
  logic [7:0]         a_r, a_nxt;
  logic [8:0]         b_r, b_nxt;
  logic [11:0]        d_r, d_nxt;

  logic [8:0]         na;
  logic signed [9:0]  b_ext;
  logic signed [9:0]  nb;
  logic signed [9:0]  diff;
  logic [11:0]        d_step;
  logic               done;
  logic               is_start;

  assign is_start = (op_t'(op) == OP_START);

  always_comb begin
    na    = {1'b0, a_r} + 9'd1;
    b_ext = $signed({b_r[8], b_r});
    diff  = $signed({1'b0, na}) - b_ext;
    if (d_r[11]) begin
      // decision negative: b holds
      nb     = b_ext;
      d_step = d_r + {1'b0, na, 2'b00} + 12'd6;
    end else begin
      nb     = b_ext - 10'sd1;
      d_step = d_r + 12'd10 + {diff[9:0], 2'b00};
    end
    done = $signed({2'b00, na}) > $signed({nb[9], nb});
  end

  assign q_push = acc && !is_start && active_r;

  always_comb begin
    q_job.cx    = cx_r;
    q_job.cy    = cy_r;
    q_job.color = color_r;
    q_job.a     = a_r;
    q_job.b     = $signed(b_r);
    q_job.done  = done;
  end

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    d_nxt      = d_r;
    if (acc && is_start) begin
      active_nxt = 1'b1;
      cx_nxt     = center_x;
      cy_nxt     = center_y;
      color_nxt  = pen_color;
      a_nxt      = 8'd0;
      b_nxt      = {1'b0, radius};
      d_nxt      = 12'd3 - {3'b000, radius, 1'b0};
    end else if (q_push) begin
      a_nxt = na[7:0];
      b_nxt = nb[8:0];
      d_nxt = d_step;
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      a_r      <= '0;
      b_r      <= '0;
      d_r      <= '0;
    end else begin
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      d_r      <= d_nxt;
    end
  end

  assign active = active_r;

endmodule

FILE: sv/cog_queue.sv
// short job queue between the front and back parts
module cog_queue
  import cog_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  job_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/cog_back.sv
// back part: walks the eight octant points of each job into the output register
module cog_back
  import cog_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] point_x,
  output logic [15:0] point_y,
  output logic [15:0] point_color,
  output logic        last_in_step,
  output logic        circle_done
);

  localparam logic [15:0] CMASK = 16'((32'd1 << COORD_BITS) - 32'd1);

  job_t                 job_r;
  logic                 job_valid_r;
  logic [PT_IDX_W-1:0]  idx_r;
  logic                 out_valid_r;
  logic [15:0]          x_nxt, y_nxt;
  logic [15:0]          x_r, y_r, color_r;
  logic                 last_r, done_r;

  logic        pop_ok, take, at_last, need_job;
  logic [15:0] aw, bw;

  assign pop_ok   = pop && out_valid_r;
  assign take     = job_valid_r && (!out_valid_r || pop_ok);
  assign at_last  = (idx_r == LAST_PT);
  assign need_job = !job_valid_r || (take && at_last);
  assign q_pop    = need_job && !q_empty;

  assign aw = {8'd0, job_r.a};
  assign bw = {{7{job_r.b[8]}}, job_r.b};

  // octant order around the center
  always_comb begin
    case (idx_r)
      3'd0:    begin x_nxt = job_r.cx + aw; y_nxt = job_r.cy - bw; end
      3'd1:    begin x_nxt = job_r.cx + bw; y_nxt = job_r.cy - aw; end
      3'd2:    begin x_nxt = job_r.cx + bw; y_nxt = job_r.cy + aw; end
      3'd3:    begin x_nxt = job_r.cx + aw; y_nxt = job_r.cy + bw; end
      3'd4:    begin x_nxt = job_r.cx - aw; y_nxt = job_r.cy + bw; end
      3'd5:    begin x_nxt = job_r.cx - bw; y_nxt = job_r.cy + aw; end
      3'd6:    begin x_nxt = job_r.cx - aw; y_nxt = job_r.cy - bw; end
      default: begin x_nxt = job_r.cx - bw; y_nxt = job_r.cy - aw; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (take) begin
        if (at_last) begin
          job_valid_r <= 1'b0;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (pop_ok) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (take) begin
      x_r     <= x_nxt & CMASK;
      y_r     <= y_nxt & CMASK;
      color_r <= job_r.color;
      last_r  <= at_last;
      done_r  <= job_r.done;
    end
  end

  assign empty        = !out_valid_r;
  assign point_x      = x_r;
  assign point_y      = y_r;
  assign point_color  = color_r;
  assign last_in_step = last_r;
  assign circle_done  = done_r;

endmodule

FILE: sv/circle_outline_generator.sv
// top level of the midpoint circle outline generator
//
//   channel   ports                                    handshake
//   -------   --------------------------------------   -------------------
//   input     in_op in_center_x in_center_y            push / full
//             in_radius in_pen_color
//   result    out_point_x out_point_y out_point_color  empty / pop
//             out_last_in_step out_circle_done
//
// a start word loads the circle into the front registers and gives no result
// each step word while a circle runs gives eight words, one per cycle while each is
// popped at once, so a steady run of steps is paced by the single output register
// the front takes a new word every cycle while the two-entry job queue has room
// reset (rst_n low, synchronous) idles the circle and empties queue and output
// a stalled pop holds the output word; the back then stops, the queue fills
// and full rises to hold off further words
module circle_outline_generator
  import cog_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [15:0] in_center_x,
  input  logic [15:0] in_center_y,
  input  logic [7:0]  in_radius,
  input  logic [15:0] in_pen_color,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_point_x,
  output logic [15:0] out_point_y,
  output logic [15:0] out_point_color,
  output logic        out_last_in_step,
  output logic        out_circle_done
);

  logic in_acc;      // input word taken this cycle
  logic q_push;      // front hands one step job to the queue
  logic q_pop;       // back takes the oldest job
  logic q_full;
  logic q_empty;
  logic front_active;
  job_t wr_job;
  job_t rd_job;

  // full only reflects the job queue; a start word never needs a slot
  assign full   = q_full;
  assign in_acc = push && !q_full;

  // front: start loads center, radius, color; step runs one midpoint update
  cog_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .op        (in_op),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .pen_color (in_pen_color),
    .q_push    (q_push),
    .q_job     (wr_job),
    .active    (front_active)
  );

  // decouples the front, one job per step word, from the back, eight points per job
  cog_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  // back: eight octant points per job, wrapped to COORD_BITS
  cog_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (rd_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .point_x      (out_point_x),
    .point_y      (out_point_y),
    .point_color  (out_point_color),
    .last_in_step (out_last_in_step),
    .circle_done  (out_circle_done)
  );

  // the queue is never written while it has no room
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue written while full");

  // the back never takes a job from an empty queue
  a_no_underrun : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  // a step word while idle makes no job
  a_idle_step : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op_t'(in_op) == OP_STEP) && !front_active) |-> !q_push)
    else $error("job made for a step while idle");

  // the final step of a circle leaves the front idle
  a_done_idles : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && wr_job.done) |=> !front_active)
    else $error("circle still running after its final step");

endmodule
